### src/frfc_pkg.sv
// ----------------------------------------------------------------------------
// frfc_pkg: shared definitions for the float / register field converter
// Format codes, command codes, register indexes and fixed limits.
// ----------------------------------------------------------------------------
package frfc_pkg;

  localparam int WORD_BITS     = 32;
  localparam int UINT_CAP_BITS = 30;

  typedef enum logic [2:0] {
    FMT_UINT   = 3'd0,
    FMT_SM_INT = 3'd1,
    FMT_TC_INT = 3'd2,
    FMT_UFIX   = 3'd3,
    FMT_SM_FIX = 3'd4,
    FMT_TC_FIX = 3'd5
  } fmt_t;

  typedef enum logic {
    CMD_PACK   = 1'b0,
    CMD_UNPACK = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_FORMAT = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_SHIFT  = 3'd2,
    REG_FRAC   = 3'd3,
    REG_SAT    = 3'd4
  } reg_idx_t;

endpackage

### src/float_register_field_converter.sv
// ----------------------------------------------------------------------------
// float_register_field_converter
// Packs an IEEE single into a field of a register word, or unpacks a field
// back to an IEEE single, in a three-stage pipeline.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (low bit up)
// s_*      in   tuser: cmd; tdata: float_in[31:0], reg_in[63:32]
// m_*      out  tdata: reg_out[31:0], float_out[63:32]
// cfg_*    in   cfg_index: register index; cfg_data: register value
//
// One request per cycle is taken while the output is not stalled.
// Stage 1 decodes the float or extracts the field, stage 2 clamps the code or
// normalizes the magnitude, stage 3 merges the field or rounds the mantissa.
// A stalled output holds every stage; nothing is lost or repeated.
// rst clears the valid bits and loads the register reset values.
module float_register_field_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // float_in, reg_in
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // reg_out, float_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  // configuration
  logic [2:0] fmt;
  logic [5:0] width;
  logic [4:0] shift;
  logic [4:0] frac;
  logic       sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt   <= frfc_pkg::FMT_UINT;
      width <= 6'd32;
      shift <= 5'd0;
      frac  <= 5'd0;
      sat   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        frfc_pkg::REG_FORMAT: fmt   <= cfg_data[2:0];
        frfc_pkg::REG_WIDTH:  width <= cfg_data;
        frfc_pkg::REG_SHIFT:  shift <= cfg_data[4:0];
        frfc_pkg::REG_FRAC:   frac  <= cfg_data[4:0];
        frfc_pkg::REG_SAT:    sat   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // static decode of the configuration
  logic [5:0]  w;
  logic [4:0]  nf;
  logic [31:0] mask, fmask, sb;
  logic [32:0] wmask;
  logic        fmt_ok, is_u, is_sm;

  always_comb begin
    w = (width == 6'd0) ? 6'd1 : (width > 6'd32) ? 6'd32 : width;
    case (fmt)
      frfc_pkg::FMT_UFIX, frfc_pkg::FMT_TC_FIX:
        nf = ({1'b0, frac} > w) ? w[4:0] : frac;
      frfc_pkg::FMT_SM_FIX:
        nf = ({1'b0, frac} > w - 6'd1) ? 5'(w - 6'd1) : frac;
      default: nf = 5'd0;
    endcase
    wmask  = (33'd1 << w) - 33'd1;
    mask   = wmask[31:0] << shift;
    fmask  = mask >> shift;
    sb     = 32'd1 << (w - 6'd1);
    fmt_ok = fmt <= frfc_pkg::FMT_TC_FIX;
    is_u   = fmt == frfc_pkg::FMT_UINT || fmt == frfc_pkg::FMT_UFIX;
    is_sm  = fmt == frfc_pkg::FMT_SM_INT || fmt == frfc_pkg::FMT_SM_FIX;
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- stage 1 ----------------
  logic        v1, c1, neg1, hi1;
  logic [31:0] reg1, mag1;
  logic        neg_a, hi_a;
  logic [31:0] mag_a, fv;
  logic [7:0]  e;
  logic [23:0] m;
  logic signed [10:0] kk;
  logic [10:0] ns;
  logic [24:0] t;
  logic [63:0] sh;

  always_comb begin
    e     = s_tdata[30:23];
    m     = (e == 8'd0) ? {1'b0, s_tdata[22:0]} : {1'b1, s_tdata[22:0]};
    kk    = ((e == 8'd0) ? 11'sd1 : $signed({3'b0, e})) - 11'sd150
            + $signed({6'b0, nf});
    ns    = 11'(-kk);
    t     = 25'({1'b0, m} >> (ns[4:0] - 5'd1));
    sh    = {40'b0, m} << kk[5:0];
    fv    = (s_tdata[63:32] & mask) >> shift;
    neg_a = 1'b0;
    hi_a  = 1'b0;
    mag_a = 32'd0;
    if (s_tuser == frfc_pkg::CMD_UNPACK) begin
      if (is_u) begin
        mag_a = fv;
      end else if (is_sm) begin
        mag_a = fv & ~sb;
        neg_a = (fv & sb) != 32'd0;
      end else begin
        neg_a = (fv & sb) != 32'd0;
        mag_a = neg_a ? ((32'd0 - fv) & fmask) : fv;
      end
    end else begin
      neg_a = s_tdata[31] && (s_tdata[30:0] != 31'd0);
      if (e == 8'hff) begin
        if (s_tdata[22:0] != 23'd0) neg_a = 1'b0;  // NaN packs as zero
        else hi_a = 1'b1;
      end else if (!kk[10]) begin
        if (kk >= 11'sd40) begin
          hi_a = 1'b1;
        end else begin
          mag_a = sh[31:0];
          hi_a  = sh[63:32] != 32'd0;
        end
      end else if (ns <= 11'd25) begin
        mag_a = 32'(t[24:1]) + 32'(t[0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
    if (en) begin
      c1   <= s_tuser;
      reg1 <= s_tdata[63:32];
      mag1 <= mag_a;
      neg1 <= neg_a;
      hi1  <= hi_a;
    end
  end

  // ---------------- stage 2 ----------------
  logic        v2, c2, neg2, z2;
  logic [31:0] reg2, val2;
  logic [4:0]  p2;
  logic [31:0] cap, clamp, code, nrm;
  logic [4:0]  p_b;

  always_comb begin
    if (is_u) begin
      cap = wmask[31:0];
      if (fmt == frfc_pkg::FMT_UINT && w > 6'(frfc_pkg::UINT_CAP_BITS))
        cap = (32'd1 << frfc_pkg::UINT_CAP_BITS) - 32'd1;
    end else if (!is_sm && neg1) begin
      cap = sb;
    end else begin
      cap = sb - 32'd1;
    end
    clamp = (sat && (hi1 || mag1 > cap)) ? cap : mag1;
    if (is_u)       code = neg1 ? 32'd0 : clamp;
    else if (is_sm) code = (clamp & ~sb) | (neg1 ? sb : 32'd0);
    else            code = neg1 ? 32'd0 - clamp : clamp;

    p_b = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag1[i]) p_b = 5'(i);
    end
    nrm = mag1 << (5'd31 - p_b);
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      c2   <= c1;
      reg2 <= reg1;
      val2 <= (c1 == frfc_pkg::CMD_UNPACK) ? nrm : code;
      p2   <= p_b;
      neg2 <= neg1;
      z2   <= mag1 == 32'd0;
    end
  end

  // ---------------- stage 3 ----------------
  logic        up;
  logic [24:0] q;
  logic [7:0]  ex;
  logic [31:0] flt, rout, fout;

  always_comb begin
    up  = val2[7] && ((val2[6:0] != 7'd0) || val2[8]);
    q   = {1'b0, val2[31:8]} + 25'(up);
    ex  = 8'(8'd127 + {3'b0, p2} - {3'b0, nf} + 8'(q[24]));
    flt = z2 ? {neg2, 31'd0} : {neg2, ex, (q[24] ? 23'd0 : q[22:0])};
    rout = reg2;
    fout = 32'd0;
    if (fmt_ok) begin
      if (c2 == frfc_pkg::CMD_UNPACK) fout = flt;
      else rout = ((val2 << shift) & mask) | (reg2 & ~mask);
    end
  end

  logic c3;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= v2;
    if (en) begin
      m_tdata <= {fout, rout};
      c3      <= c2;
    end
  end

`ifndef SYNTHESIS
  a_pack_float_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && c3 == frfc_pkg::CMD_PACK |-> m_tdata[63:32] == 32'd0)
    else $error("pack request produced nonzero float_out");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready out of step with output stage");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid && !v1 && !v2)
    else $error("pipeline valid bits set after reset");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    en && v2 |=> m_tvalid)
    else $error("stage 2 request lost");
`endif

endmodule
